>>> hdl/dedup_packet_fifo_with_range_count_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the deduplicating packet FIFO
// Clocked concurrent checks, disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef DEDUP_PACKET_FIFO_WITH_RANGE_COUNT_ASSERT_SVH
`define DEDUP_PACKET_FIFO_WITH_RANGE_COUNT_ASSERT_SVH

// Same-cycle implication
`define DPFRC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle check");

// Next-cycle implication
`define DPFRC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle check");

`endif

>>> hdl/dpfrc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpfrc_pkg
// Shared types, codes and constants of the deduplicating packet FIFO.
// ----------------------------------------------------------------------------
package dpfrc_pkg;

	localparam int unsigned DEPTH_DEFAULT = 1024;
	localparam int unsigned LIMIT_W       = 11;
	localparam int unsigned LIMIT_RESET   = 1024;
	localparam int unsigned COUNT_W       = 11;
	localparam int unsigned COUNT_MAX     = 2047;

	typedef enum logic [1:0] {
		OP_ADD   = 2'd0,
		OP_FWD   = 2'd1,
		OP_COUNT = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [15:0] src_id;
		logic [15:0] dst_id;
		logic [31:0] stamp;
		logic [31:0] window_start;
		logic [31:0] window_end;
	} in_item_t;

	typedef struct packed {
		logic        accepted;
		logic        packet_valid;
		logic [15:0] out_src;
		logic [15:0] out_dst;
		logic [31:0] out_stamp;
		logic [10:0] match_count;
	} out_item_t;

	typedef struct packed {
		logic [15:0] src;
		logic [15:0] dst;
		logic [31:0] stamp;
	} entry_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic issue;
		logic finish;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic len_zero;
		logic issue_last;
	} ctrl_status_t;

endpackage

>>> hdl/dpfrc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpfrc_ctrl
// Sequencer: prepare, scan live entries, drain the read stage, finish.
// ----------------------------------------------------------------------------
module dpfrc_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  dpfrc_pkg::ctrl_status_t status,
	output dpfrc_pkg::ctrl_cmd_t    cmd,
	output logic                    busy
);

	dpfrc_pkg::state_t state_q;
	dpfrc_pkg::state_t state_next;

	// hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dpfrc_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// advance sequence
	always_comb begin
		state_next = state_q;
		cmd        = '0;
		busy       = 1'b1;
		case (state_q)
			dpfrc_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load   = 1'b1;
					state_next = dpfrc_pkg::ST_PREP;
				end
			end
			dpfrc_pkg::ST_PREP: begin
				state_next = status.len_zero ? dpfrc_pkg::ST_FINISH : dpfrc_pkg::ST_SCAN;
			end
			dpfrc_pkg::ST_SCAN: begin
				cmd.issue = 1'b1;
				if (status.issue_last) begin
					state_next = dpfrc_pkg::ST_DRAIN;
				end
			end
			dpfrc_pkg::ST_DRAIN: begin
				state_next = dpfrc_pkg::ST_FINISH;
			end
			dpfrc_pkg::ST_FINISH: begin
				cmd.finish = 1'b1;
				state_next = dpfrc_pkg::ST_IDLE;
			end
			default: begin
				state_next = dpfrc_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

>>> hdl/dpfrc_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpfrc_dp
// Packet store, ring pointers, scan compare and result register.
// ----------------------------------------------------------------------------
module dpfrc_dp #(
	parameter int unsigned DEPTH = dpfrc_pkg::DEPTH_DEFAULT
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  dpfrc_pkg::in_item_t     item,
	input  logic                    cfg_we,
	input  logic [10:0]             cfg_data,
	input  dpfrc_pkg::ctrl_cmd_t    cmd,
	output dpfrc_pkg::ctrl_status_t status,
	output dpfrc_pkg::out_item_t    result,
	output logic                    result_valid
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	dpfrc_pkg::entry_t   mem [DEPTH];
	dpfrc_pkg::in_item_t cmd_q;
	dpfrc_pkg::entry_t   rd_s1;
	dpfrc_pkg::entry_t   wr_entry;
	dpfrc_pkg::out_item_t res_q;
	dpfrc_pkg::out_item_t res_d;
	logic                res_v_q;
	logic                rdv_s1;
	logic [PW-1:0]       head_q;
	logic [CW-1:0]       occ_q;
	logic [10:0]         limit_q;
	logic [CW-1:0]       idx_q;
	logic [CW-1:0]       cnt_q;
	logic                dup_q;
	logic [CW-1:0]       len;
	logic [CW:0]         rd_sum;
	logic [CW:0]         wr_sum;
	logic [PW-1:0]       rd_addr;
	logic [PW-1:0]       wr_addr;
	logic [PW-1:0]       head_inc;
	logic [31:0]         lim;
	logic                full;
	logic                wr_en;
	logic                is_dup;
	logic                is_match;

	// scan length per operation
	always_comb begin
		case (cmd_q.op)
			dpfrc_pkg::OP_ADD:   len = occ_q;
			dpfrc_pkg::OP_COUNT: len = occ_q;
			dpfrc_pkg::OP_FWD:   len = CW'(occ_q != '0);
			default:             len = '0;
		endcase
	end

	assign status.len_zero   = (len == '0);
	assign status.issue_last = ((idx_q + CW'(1)) == len);

	// ring addresses with wrap
	always_comb begin
		rd_sum   = (CW+1)'(head_q) + (CW+1)'(idx_q);
		wr_sum   = (CW+1)'(head_q) + (CW+1)'(occ_q);
		rd_addr  = (rd_sum >= (CW+1)'(DEPTH)) ? PW'(rd_sum - (CW+1)'(DEPTH)) : PW'(rd_sum);
		wr_addr  = (wr_sum >= (CW+1)'(DEPTH)) ? PW'(wr_sum - (CW+1)'(DEPTH)) : PW'(wr_sum);
		head_inc = (head_q == PW'(DEPTH - 1)) ? '0 : head_q + PW'(1);
	end

	// effective limit, clamped to 1..DEPTH
	always_comb begin
		lim = 32'(limit_q);
		if (lim == 32'd0) begin
			lim = 32'd1;
		end
		if (lim > 32'(DEPTH)) begin
			lim = 32'(DEPTH);
		end
		full = (32'(occ_q) >= lim);
	end

	assign wr_en          = cmd.finish && (cmd_q.op == dpfrc_pkg::OP_ADD) && !dup_q;
	assign wr_entry.src   = cmd_q.src_id;
	assign wr_entry.dst   = cmd_q.dst_id;
	assign wr_entry.stamp = cmd_q.stamp;

	// store write and registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_entry;
		end
		if (cmd.issue) begin
			rd_s1 <= mem[rd_addr];
		end
	end

	// compare the beat read last cycle
	assign is_dup = (rd_s1.src == cmd_q.src_id) && (rd_s1.dst == cmd_q.dst_id)
		&& (rd_s1.stamp == cmd_q.stamp);
	assign is_match = (rd_s1.dst == cmd_q.dst_id) && (rd_s1.stamp >= cmd_q.window_start)
		&& (rd_s1.stamp <= cmd_q.window_end);

	// latch command
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q <= item;
		end
	end

	// build the result beat
	always_comb begin
		res_d = '0;
		case (cmd_q.op)
			dpfrc_pkg::OP_ADD: begin
				res_d.accepted = !dup_q;
			end
			dpfrc_pkg::OP_FWD: begin
				if (occ_q != '0) begin
					res_d.packet_valid = 1'b1;
					res_d.out_src      = rd_s1.src;
					res_d.out_dst      = rd_s1.dst;
					res_d.out_stamp    = rd_s1.stamp;
				end
			end
			dpfrc_pkg::OP_COUNT: begin
				res_d.match_count = (32'(cnt_q) > 32'(dpfrc_pkg::COUNT_MAX))
					? 11'(dpfrc_pkg::COUNT_MAX) : 11'(cnt_q);
			end
			default: begin
				res_d = '0;
			end
		endcase
	end

	// scan control, accumulators, ring state, result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			occ_q   <= '0;
			limit_q <= 11'(dpfrc_pkg::LIMIT_RESET);
			idx_q   <= '0;
			cnt_q   <= '0;
			dup_q   <= 1'b0;
			rdv_s1  <= 1'b0;
			res_v_q <= 1'b0;
			res_q   <= '0;
		end else begin
			rdv_s1  <= cmd.issue;
			res_v_q <= cmd.finish;
			if (cfg_we) begin
				limit_q <= cfg_data;
			end
			if (cmd.load) begin
				idx_q <= '0;
				cnt_q <= '0;
				dup_q <= 1'b0;
			end else if (cmd.issue) begin
				idx_q <= idx_q + CW'(1);
			end
			if (rdv_s1) begin
				if (is_dup) begin
					dup_q <= 1'b1;
				end
				if (is_match) begin
					cnt_q <= cnt_q + CW'(1);
				end
			end
			if (cmd.finish) begin
				res_q <= res_d;
				case (cmd_q.op)
					dpfrc_pkg::OP_ADD: begin
						if (!dup_q) begin
							if (full) begin
								head_q <= head_inc;
							end else begin
								occ_q <= occ_q + CW'(1);
							end
						end
					end
					dpfrc_pkg::OP_FWD: begin
						if (occ_q != '0) begin
							head_q <= head_inc;
							occ_q  <= occ_q - CW'(1);
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	assign result       = res_q;
	assign result_valid = res_v_q;

endmodule

>>> hdl/dedup_packet_fifo_with_range_count.sv
`timescale 1ns / 1ps
// Sequence: an accepted command passes through prepare, a scan that reads each packet held
//   (forward reads only the head), drain and finish; an empty scan goes from prepare to finish.
// One command at a time: start is taken only while idle; one store read per scan cycle.
// The result strobe lasts one cycle and the receiver cannot stall it.
// Reset: asynchronous, empties the FIFO, limit returns to 1024; store contents stay.
// ----------------------------------------------------------------------------
// dedup_packet_fifo_with_range_count
// Bounded packet FIFO with duplicate rejection and windowed destination count.
// ----------------------------------------------------------------------------
`include "dedup_packet_fifo_with_range_count_assert.svh"

module dedup_packet_fifo_with_range_count #(
	parameter int unsigned DEPTH = dpfrc_pkg::DEPTH_DEFAULT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  dpfrc_pkg::in_item_t  item,
	output dpfrc_pkg::out_item_t result,
	output logic                 result_valid,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [10:0]          cfg_data
);

	dpfrc_pkg::ctrl_cmd_t    cmd;
	dpfrc_pkg::ctrl_status_t status;

	// take the limit register only while idle
	assign cfg_ready = !busy;

	dpfrc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	dpfrc_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_data     (cfg_data),
		.cmd          (cmd),
		.status       (status),
		.result       (result),
		.result_valid (result_valid)
	);

	`DPFRC_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy)
	`DPFRC_ASSERT_SAME(a_result_after_work, clk, arst_n, result_valid, $past(busy))
	`DPFRC_ASSERT_SAME(a_one_kind, clk, arst_n, result_valid, !(result.accepted && result.packet_valid))

endmodule

>>> test/dedup_packet_fifo_with_range_count_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dedup_packet_fifo_with_range_count_tb
// Drives add, forward, count and unused commands into the packet FIFO under
// several capacity limits and sender gap rates. Each result beat is predicted
// by a behavioral packet queue or given by a directed row, and checked by field.
// ----------------------------------------------------------------------------
module dedup_packet_fifo_with_range_count_tb;

	localparam int QDEPTH   = 1024;
	localparam int WDOG_MAX = 20000;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	dpfrc_pkg::in_item_t  item;
	dpfrc_pkg::out_item_t result;
	logic                 result_valid;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [10:0]          cfg_data;

	dedup_packet_fifo_with_range_count uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.result(result), .result_valid(result_valid),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	// shadow packet queue
	dpfrc_pkg::entry_t shadow_pkts [QDEPTH];
	int unsigned       shadow_head;
	int unsigned       shadow_occ;
	int unsigned       shadow_limit;

	dpfrc_pkg::out_item_t pending_results [$];
	int                   errors;
	int                   items_sent;
	int                   beats_seen;
	int                   adds_taken;
	int                   wdog;
	int                   gap_pct;

	typedef struct {
		dpfrc_pkg::in_item_t  cmd;
		bit                   typed;
		dpfrc_pkg::out_item_t want;
	} dir_row_t;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// compute the result of one command and advance the shadow queue
	function automatic dpfrc_pkg::out_item_t fifo_step(dpfrc_pkg::in_item_t x);
		dpfrc_pkg::out_item_t r;
		int unsigned          lim;
		int unsigned          s;
		int unsigned          cnt;
		r = '0;
		cnt = 0;
		lim = (shadow_limit == 0) ? 1 : (shadow_limit > QDEPTH ? QDEPTH : shadow_limit);
		case (dpfrc_pkg::op_t'(x.op))
			dpfrc_pkg::OP_ADD: begin
				for (int i = 0; i < shadow_occ; i++) begin
					s = (shadow_head + i) % QDEPTH;
					if (shadow_pkts[s].src == x.src_id && shadow_pkts[s].dst == x.dst_id &&
					    shadow_pkts[s].stamp == x.stamp)
						return r;
				end
				if (shadow_occ >= lim && shadow_occ != 0) begin
					shadow_head = (shadow_head + 1) % QDEPTH;
					shadow_occ--;
				end
				s = (shadow_head + shadow_occ) % QDEPTH;
				shadow_pkts[s] = '{x.src_id, x.dst_id, x.stamp};
				shadow_occ++;
				r.accepted = 1'b1;
			end
			dpfrc_pkg::OP_FWD: begin
				if (shadow_occ != 0) begin
					r.packet_valid = 1'b1;
					r.out_src = shadow_pkts[shadow_head].src;
					r.out_dst = shadow_pkts[shadow_head].dst;
					r.out_stamp = shadow_pkts[shadow_head].stamp;
					shadow_head = (shadow_head + 1) % QDEPTH;
					shadow_occ--;
				end
			end
			dpfrc_pkg::OP_COUNT: begin
				for (int i = 0; i < shadow_occ; i++) begin
					s = (shadow_head + i) % QDEPTH;
					if (shadow_pkts[s].dst == x.dst_id && shadow_pkts[s].stamp >= x.window_start &&
					    shadow_pkts[s].stamp <= x.window_end)
						cnt++;
				end
				r.match_count = (cnt > dpfrc_pkg::COUNT_MAX) ? 11'(dpfrc_pkg::COUNT_MAX)
					: 11'(cnt);
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	// send one command beat, with random sender gaps before it
	task automatic issue_cmd(dpfrc_pkg::in_item_t x, bit typed, dpfrc_pkg::out_item_t want);
		dpfrc_pkg::out_item_t p;
		while ($urandom_range(99) < gap_pct) begin
			@(negedge clk);
			start = 1'b0;
		end
		@(negedge clk);
		item = x;
		start = 1'b1;
		do @(posedge clk); while (busy);
		p = fifo_step(x);
		pending_results.insert(pending_results.size(), typed ? want : p);
		items_sent++;
	endtask

	// drain all results, then write the limit register
	task automatic set_limit(logic [10:0] v);
		@(negedge clk);
		start = 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_data = v;
		do @(posedge clk); while (!cfg_ready);
		shadow_limit = v;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// random command, mostly from small pools so duplicates and matches occur
	function automatic dpfrc_pkg::in_item_t rand_cmd();
		dpfrc_pkg::in_item_t x;
		int unsigned         k;
		int unsigned         pick;
		x.window_start = $urandom();
		x.window_end = $urandom();
		x.src_id = ($urandom_range(9) == 0) ? 16'($urandom()) : 16'($urandom_range(3));
		x.dst_id = ($urandom_range(9) == 0) ? 16'($urandom()) : 16'($urandom_range(3));
		x.stamp = ($urandom_range(9) == 0) ? $urandom() : 32'($urandom_range(20));
		pick = $urandom_range(99);
		if (pick < 50) begin
			x.op = dpfrc_pkg::OP_ADD;
			if (shadow_occ != 0 && $urandom_range(3) == 0) begin
				k = (shadow_head + $urandom_range(shadow_occ - 1)) % QDEPTH;
				x.src_id = shadow_pkts[k].src;
				x.dst_id = shadow_pkts[k].dst;
				x.stamp = shadow_pkts[k].stamp;
			end
		end else if (pick < 72) begin
			x.op = dpfrc_pkg::OP_FWD;
		end else if (pick < 96) begin
			x.op = dpfrc_pkg::OP_COUNT;
			if ($urandom_range(3) != 0) begin
				x.window_start = 32'($urandom_range(12));
				x.window_end = 32'($urandom_range(8, 24));
			end
		end else begin
			x.op = dpfrc_pkg::OP_NONE;
		end
		return x;
	endfunction

	// check each result beat against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && result_valid) begin
			beats_seen++;
			if (pending_results.size() == 0) begin
				$display("%0t: result beat with none pending, expected none, actual %h",
				         $time, result);
				errors++;
			end else begin
				dpfrc_pkg::out_item_t w;
				w = pending_results[0];
				pending_results.delete(0);
				if (result.accepted !== w.accepted)
					$display("%0t: accepted expected %b actual %b", $time, w.accepted,
					         result.accepted);
				if (result.packet_valid !== w.packet_valid)
					$display("%0t: packet_valid expected %b actual %b", $time,
					         w.packet_valid, result.packet_valid);
				if (result.out_src !== w.out_src)
					$display("%0t: out_src expected %h actual %h", $time, w.out_src,
					         result.out_src);
				if (result.out_dst !== w.out_dst)
					$display("%0t: out_dst expected %h actual %h", $time, w.out_dst,
					         result.out_dst);
				if (result.out_stamp !== w.out_stamp)
					$display("%0t: out_stamp expected %h actual %h", $time, w.out_stamp,
					         result.out_stamp);
				if (result.match_count !== w.match_count)
					$display("%0t: match_count expected %0d actual %0d", $time,
					         w.match_count, result.match_count);
				if (result !== w)
					errors++;
				if (w.accepted)
					adds_taken++;
			end
		end
	end

	// stop a hung run: count cycles with no beat moving
	always @(posedge clk) begin
		if ((start && !busy) || result_valid || (cfg_valid && cfg_ready))
			wdog <= 0;
		else
			wdog <= wdog + 1;
		if (wdog >= WDOG_MAX) begin
			$display("%0t: watchdog expired", $time);
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		dir_row_t             dir_rows [$];
		logic [10:0]          phase_limit [7];
		int                   phase_gap [7];
		dpfrc_pkg::out_item_t z;
		dpfrc_pkg::in_item_t  c;

		phase_limit = '{11'd2047, 11'd0, 11'd5, 11'd1, 11'd16, 11'd1024, 11'd3};
		phase_gap = '{0, 73, 21, 0, 73, 21, 0};
		errors = 0;
		items_sent = 0;
		beats_seen = 0;
		adds_taken = 0;
		wdog = 0;
		gap_pct = 0;
		shadow_head = 0;
		shadow_occ = 0;
		shadow_limit = dpfrc_pkg::LIMIT_RESET;
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed rows: empty buffer, field extremes, duplicates, windows
		z = '0;
		c = '0;
		c.op = dpfrc_pkg::OP_FWD;   dir_rows.insert(dir_rows.size(), '{c, 1, z});
		c.op = dpfrc_pkg::OP_COUNT; c.window_end = '1;
		dir_rows.insert(dir_rows.size(), '{c, 1, z});
		c = '1; c.op = dpfrc_pkg::OP_NONE; dir_rows.insert(dir_rows.size(), '{c, 1, z});
		c = '1; c.op = dpfrc_pkg::OP_ADD;
		z.accepted = 1'b1; dir_rows.insert(dir_rows.size(), '{c, 1, z});
		z = '0;            dir_rows.insert(dir_rows.size(), '{c, 1, z});
		c = '0; c.op = dpfrc_pkg::OP_ADD; c.window_start = '1; c.window_end = '1;
		z.accepted = 1'b1; dir_rows.insert(dir_rows.size(), '{c, 1, z});
		z = '0;
		c = '0; c.op = dpfrc_pkg::OP_ADD; c.src_id = 16'h5555; c.dst_id = 16'hAAAA;
		c.stamp = 32'h5555_AAAA; dir_rows.insert(dir_rows.size(), '{c, 0, z});
		c.op = dpfrc_pkg::OP_COUNT; c.dst_id = 16'hFFFF; c.window_start = 0; c.window_end = '1;
		z.match_count = 11'd1; dir_rows.insert(dir_rows.size(), '{c, 1, z});
		z = '0;
		c.window_start = '1; c.window_end = 0; dir_rows.insert(dir_rows.size(), '{c, 1, z});
		c.window_start = '1; c.window_end = '1; z.match_count = 11'd1;
		dir_rows.insert(dir_rows.size(), '{c, 1, z});
		z = '0;
		c.dst_id = 16'hAAAA; c.window_start = 32'h5555_AAAA; c.window_end = 32'h5555_AAAA;
		dir_rows.insert(dir_rows.size(), '{c, 0, z});
		c.dst_id = 0; c.window_start = 0; c.window_end = 0;
		dir_rows.insert(dir_rows.size(), '{c, 0, z});
		c = '0; c.op = dpfrc_pkg::OP_NONE; dir_rows.insert(dir_rows.size(), '{c, 1, z});
		c = '0; c.op = dpfrc_pkg::OP_FWD;
		z.packet_valid = 1'b1; z.out_src = '1; z.out_dst = '1; z.out_stamp = '1;
		dir_rows.insert(dir_rows.size(), '{c, 1, z});
		z = '0;
		dir_rows.insert(dir_rows.size(), '{c, 0, z});
		dir_rows.insert(dir_rows.size(), '{c, 0, z});
		dir_rows.insert(dir_rows.size(), '{c, 1, z});
		foreach (dir_rows[i])
			issue_cmd(dir_rows[i].cmd, dir_rows[i].typed, dir_rows[i].want);

		// random phases, each under its own limit and gap rate
		for (int ph = 0; ph < 7; ph++) begin
			set_limit(phase_limit[ph]);
			gap_pct = phase_gap[ph];
			repeat (80) issue_cmd(rand_cmd(), 1'b0, '0);
		end

		@(negedge clk);
		start = 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		$display("Sent %0d commands under 8 limit settings; %0d result beats, %0d adds stored.",
		         items_sent, beats_seen, adds_taken);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+hdl
hdl/dpfrc_pkg.sv
hdl/dpfrc_ctrl.sv
hdl/dpfrc_dp.sv
hdl/dedup_packet_fifo_with_range_count.sv
test/dedup_packet_fifo_with_range_count_tb.sv
